// ===== src/mst_pkg.sv =====
`default_nettype none

package mst_pkg;

  localparam int SLOTS_DEFAULT = 8;
  // the slot field is three bits wide, so at most eight slots are reachable
  localparam int SLOT_LIMIT    = 8;

  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 3;
  localparam int VAL_W    = 32;
  localparam int TICK_W   = 64;
  localparam int RES_W    = 2;
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_ARM    = 3'd0,
    KIND_SETCNT = 3'd1,
    KIND_STOP   = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_TICK   = 3'd4,
    KIND_SCAN   = 3'd5
  } cmd_kind_t;

  typedef enum logic [RES_W-1:0] {
    RES_STATUS = 2'd0,
    RES_FIRE   = 2'd1,
    RES_DONE   = 2'd2
  } res_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_SCAN,
    ST_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    ADD_PERIOD_IN,
    ADD_PERIOD_SLOT,
    ADD_ONE
  } add_sel_t;

endpackage

`default_nettype wire

// ===== src/multi_slot_repeat_timer.sv =====
`default_nettype none
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tuser: kind; s_tdata: slot, period, repeat_count
// m        out  m_tvalid/m_tready  m_tuser: result_kind; m_tdata: status, fired_slot;
//                                  m_tlast: last
// A command issues its status result from ST_CMD. A scan visits each slot in
// ST_SCAN, then ST_DONE, all through one 64-bit adder and one goal compare.
// s_tready is high only while the sequencer is idle; a result register on the m
// side lets the next command be taken while the previous result waits.
// A held result stalls the sequencer at the next result it has to issue.
// rst is synchronous; it clears the tick counter, active bits and repeat counts.
module multi_slot_repeat_timer #(
  parameter int SLOTS = mst_pkg::SLOTS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [mst_pkg::KIND_W-1:0]   s_tuser,   // kind
  // slot[2:0], period[34:3], repeat_count[66:35], zero pad[71:67]
  input  wire logic [mst_pkg::S_DATA_W-1:0] s_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [mst_pkg::RES_W-1:0]         m_tuser,   // result_kind
  // status[0], fired_slot[3:1], zero pad[7:4]
  output logic [mst_pkg::M_DATA_W-1:0]      m_tdata,
  output logic                              m_tlast
);
  import mst_pkg::*;

  localparam int NUM   = (SLOTS < SLOT_LIMIT) ? SLOTS : SLOT_LIMIT;
  localparam int IDX_W = (NUM > 1) ? $clog2(NUM) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM - 1);
  localparam int PAD_W = M_DATA_W - SLOT_W - 1;

  seq_state_t state, state_next;

  logic [KIND_W-1:0] kind_q;
  logic [VAL_W-1:0]  period_q;
  logic [VAL_W-1:0]  count_q;
  logic              slot_ok_q;
  logic [IDX_W-1:0]  idx;
  logic [TICK_W-1:0] tick_count;

  logic              slot_active    [NUM];
  logic [VAL_W-1:0]  slot_remaining [NUM];
  logic [VAL_W-1:0]  slot_period    [NUM];
  logic [TICK_W-1:0] slot_goal      [NUM];

  logic              rd_active;
  logic [VAL_W-1:0]  rd_rem;
  logic [VAL_W-1:0]  rd_period;
  logic [TICK_W-1:0] rd_goal;
  logic [VAL_W-1:0]  rem_dec;
  logic              fire;
  logic              out_free;
  logic              s_accept;

  add_sel_t          add_sel;
  logic [TICK_W-1:0] add_b;
  logic [TICK_W-1:0] add_sum;

  logic              out_load;
  res_kind_t         out_kind;
  logic              out_status;
  logic [SLOT_W-1:0] out_slot;
  logic              out_last;
  logic              arm_we;
  logic              rem_we;
  logic [VAL_W-1:0]  rem_val;
  logic              goal_we;
  logic              deact_we;
  logic              tick_we;
  logic              idx_inc;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign rd_active = slot_active[idx];
  assign rd_rem    = slot_remaining[idx];
  assign rd_period = slot_period[idx];
  assign rd_goal   = slot_goal[idx];
  assign rem_dec   = rd_rem - VAL_W'(1);
  assign fire      = rd_active && (rd_rem != '0) && (tick_count >= rd_goal);

  // shared adder: arm goal, re-arm goal and tick increment
  always_comb begin
    case (add_sel)
      ADD_PERIOD_IN:   add_b = TICK_W'(period_q);
      ADD_PERIOD_SLOT: add_b = TICK_W'(rd_period);
      default:         add_b = TICK_W'(1);
    endcase
  end
  assign add_sum = tick_count + add_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    add_sel    = ADD_PERIOD_IN;
    out_load   = 1'b0;
    out_kind   = RES_STATUS;
    out_status = 1'b0;
    out_slot   = '0;
    out_last   = 1'b1;
    arm_we     = 1'b0;
    rem_we     = 1'b0;
    rem_val    = count_q;
    goal_we    = 1'b0;
    deact_we   = 1'b0;
    tick_we    = 1'b0;
    idx_inc    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser == KIND_SCAN) ? ST_SCAN : ST_CMD;
        end
      end
      ST_CMD: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
          case (kind_q)
            KIND_ARM: begin
              arm_we = slot_ok_q;
            end
            KIND_SETCNT: begin
              if (slot_ok_q && rd_active) begin
                rem_we = 1'b1;
              end else begin
                out_status = 1'b1;
              end
            end
            KIND_STOP: begin
              rem_we  = slot_ok_q;
              rem_val = '0;
            end
            KIND_REMOVE: begin
              if (slot_ok_q && rd_active) begin
                deact_we = 1'b1;
              end else begin
                out_status = 1'b1;
              end
            end
            KIND_TICK: begin
              tick_we = 1'b1;
              add_sel = ADD_ONE;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        add_sel = ADD_PERIOD_SLOT;
        // a firing slot waits for the result register; others pass at once
        if (!fire || out_free) begin
          if (fire) begin
            out_load = 1'b1;
            out_kind = RES_FIRE;
            out_slot = SLOT_W'(idx);
            out_last = 1'b0;
            rem_we   = 1'b1;
            rem_val  = rem_dec;
            goal_we  = (rem_dec != '0);
          end
          if (idx == LAST_IDX) begin
            state_next = ST_DONE;
          end else begin
            idx_inc = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind   = RES_DONE;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command capture and slot index
  always_ff @(posedge clk) begin
    if (s_accept) begin
      kind_q    <= s_tuser;
      period_q  <= s_tdata[SLOT_W +: VAL_W];
      count_q   <= s_tdata[SLOT_W + VAL_W +: VAL_W];
      slot_ok_q <= ((SLOT_W + 1)'(s_tdata[SLOT_W-1:0]) < (SLOT_W + 1)'(NUM));
      idx       <= (s_tuser == KIND_SCAN) ? '0 : s_tdata[IDX_W-1:0];
    end else if (idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (tick_we) begin
      tick_count <= add_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM; i++) begin
        slot_active[i]    <= 1'b0;
        slot_remaining[i] <= '0;
      end
    end else begin
      if (arm_we) begin
        slot_active[idx]    <= 1'b1;
        slot_remaining[idx] <= count_q;
      end else if (rem_we) begin
        slot_remaining[idx] <= rem_val;
      end
      if (deact_we) begin
        slot_active[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (arm_we) begin
      slot_period[idx] <= period_q;
    end
    if (arm_we || goal_we) begin
      slot_goal[idx] <= add_sum;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= out_kind;
      m_tdata <= {PAD_W'(0), out_slot, out_status};
      m_tlast <= out_last;
    end
  end

  // fired slot always lies within the table
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == RES_FIRE) |-> ((SLOT_W + 1)'(m_tdata[SLOT_W:1]) < (SLOT_W + 1)'(NUM)))
    else $error("fired slot outside the table");

  // last marks status and done results only
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == RES_STATUS || m_tuser == RES_DONE)))
    else $error("last flag does not match result kind");

  // an executed tick advances the counter by exactly one
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMD && out_free && kind_q == KIND_TICK)
      |=> (tick_count == $past(tick_count) + TICK_W'(1)))
    else $error("tick counter did not advance");

  // the sequencer takes no transaction while a scan is running
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> (!s_tready || $past(idx) == LAST_IDX || $past(fire && !out_free)) ||
      (state != ST_SCAN))
    else $error("input taken during scan");

endmodule

`default_nettype wire
